### src/tpwc_pkg.sv
// Package for the twin prime window counter.
// Holds the beat types, the job record passed from front to back, and the FSM states.
// No dependencies.
package tpwc_pkg;

    localparam int WINDOW_DEF     = 4096;
    localparam int VALUE_BITS_DEF = 30;
    localparam int BOUND_W        = 30;
    localparam int COUNT_W        = 13;
    localparam int JOB_VAL_W      = 32;

    typedef struct packed {
        logic [BOUND_W-1:0] low_bound;
        logic [BOUND_W-1:0] high_bound;
    } in_beat_t;

    typedef struct packed {
        logic [COUNT_W-1:0] twin_count;
        logic               window_too_wide;
    } out_beat_t;

    typedef enum logic [1:0] {
        JOB_EMPTY,
        JOB_WIDE,
        JOB_SIEVE
    } job_kind_t;

    typedef struct packed {
        job_kind_t            kind;
        logic [JOB_VAL_W-1:0] lo;
        logic [JOB_VAL_W-1:0] hi;
    } job_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PRESET,
        S_MUL,
        S_CHECK,
        S_DIV,
        S_START,
        S_STRIKE,
        S_COUNT,
        S_DRAIN,
        S_DONE
    } back_state_t;

endpackage

### src/tpwc_front.sv
// Front end: accepts query beats, masks the bounds and classifies each query.
// Depends on tpwc_pkg.
module tpwc_front #(
    parameter int WINDOW     = tpwc_pkg::WINDOW_DEF,
    parameter int VALUE_BITS = tpwc_pkg::VALUE_BITS_DEF
) (
    input  logic              in_valid,
    output logic              in_ready,
    input  tpwc_pkg::in_beat_t in_data,
    output logic              job_valid,
    input  logic              job_ready,
    output tpwc_pkg::job_t    job
);
    import tpwc_pkg::*;

    localparam logic [32:0] WIN_M1 = 33'(WINDOW - 1);

    logic [VALUE_BITS-1:0] lo_v;
    logic [VALUE_BITS-1:0] hi_v;
    logic [VALUE_BITS-1:0] diff;

    // Mask bounds to the value width
    assign lo_v = VALUE_BITS'(in_data.low_bound);
    assign hi_v = VALUE_BITS'(in_data.high_bound);
    assign diff = hi_v - lo_v;

    assign in_ready  = job_ready;
    assign job_valid = in_valid;

    // Classify: empty, too wide, or a real sieve job
    always_comb
    begin
        job.lo = JOB_VAL_W'(lo_v);
        job.hi = JOB_VAL_W'(hi_v);
        if (hi_v < lo_v)
            job.kind = JOB_EMPTY;
        else if (33'(diff) > WIN_M1)
            job.kind = JOB_WIDE;
        else
            job.kind = JOB_SIEVE;
    end

endmodule

### src/tpwc_queue.sv
// Two-entry job queue between front and back ends.
// Depends on tpwc_pkg.
module tpwc_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  tpwc_pkg::job_t push_job,
    output logic           pop_valid,
    input  logic           pop_ready,
    output tpwc_pkg::job_t pop_job
);
    import tpwc_pkg::*;

    job_t       slot_reg [2];
    logic       wp_reg;
    logic       wp_next;
    logic       rp_reg;
    logic       rp_next;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (fill_reg != 2'd2);
    assign pop_valid  = (fill_reg != 2'd0);
    assign pop_job    = slot_reg[rp_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill update
    always_comb
    begin
        wp_next   = do_push ? ~wp_reg : wp_reg;
        rp_next   = do_pop ? ~rp_reg : rp_reg;
        fill_next = fill_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= 1'b0;
            rp_reg   <= 1'b0;
            fill_reg <= 2'd0;
        end
        else
        begin
            wp_reg   <= wp_next;
            rp_reg   <= rp_next;
            fill_reg <= fill_next;
        end
    end

    // Payload slots
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wp_reg] <= push_job;
    end

endmodule

### src/tpwc_back.sv
// Back end: segment bitmap, stride sieve with remainder unit, twin count and result register.
// Depends on tpwc_pkg.
module tpwc_back #(
    parameter int WINDOW     = tpwc_pkg::WINDOW_DEF,
    parameter int VALUE_BITS = tpwc_pkg::VALUE_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_valid,
    output logic                job_ready,
    input  tpwc_pkg::job_t      job,
    output logic                out_valid,
    input  logic                out_ready,
    output tpwc_pkg::out_beat_t out_data
);
    import tpwc_pkg::*;

    localparam int IW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int XW  = VALUE_BITS / 2 + 2;
    localparam int PW  = 2 * XW;
    localparam int OW  = ((IW > XW) ? IW : XW) + 1;
    localparam int DCW = $clog2(VALUE_BITS) + 1;

    back_state_t state_reg;
    back_state_t state_next;

    logic [VALUE_BITS-1:0] lo_reg;
    logic [VALUE_BITS-1:0] hi_reg;
    logic [IW-1:0]         last_reg;
    logic [XW-1:0]         x_reg;
    logic [PW-1:0]         sq_reg;
    logic [XW-1:0]         rem_reg;
    logic [DCW-1:0]        dcnt_reg;
    logic [OW-1:0]         off_reg;
    logic [IW:0]           idx_reg;
    logic                  rdv_reg;
    logic [IW:0]           rdi_reg;
    logic                  h1_reg;
    logic                  h2_reg;
    logic [COUNT_W-1:0]    cnt_reg;
    logic                  wide_reg;
    logic                  out_valid_reg;
    out_beat_t             out_reg;

    // Bitmap memory and its ports
    logic                  mem [WINDOW];
    logic                  mem_q;
    logic                  mem_we;
    logic [IW-1:0]         mem_wa;
    logic                  mem_wd;
    logic                  mem_re;
    logic [IW-1:0]         mem_ra;

    logic                  sq_above_hi;
    logic                  sq_below_lo;
    logic                  strike_more;
    logic                  div_last;
    logic [XW:0]           shifted;
    logic                  small_val;

    assign sq_above_hi = sq_reg > PW'(hi_reg);
    assign sq_below_lo = sq_reg < PW'(lo_reg);
    assign strike_more = off_reg <= OW'(last_reg);
    assign div_last    = (dcnt_reg == DCW'(VALUE_BITS - 1));
    assign shifted     = {rem_reg, lo_reg[VALUE_BITS - 1 - int'(dcnt_reg)]};
    assign small_val   = ((VALUE_BITS+1)'(lo_reg) + (VALUE_BITS+1)'(idx_reg[IW-1:0]))
                         < (VALUE_BITS+1)'(2);

    assign job_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (job_valid)
                begin
                    if (job.kind == JOB_SIEVE)
                        state_next = S_PRESET;
                    else
                        state_next = S_DONE;
                end
            end
            S_PRESET:
                if (idx_reg[IW-1:0] == last_reg)
                    state_next = S_MUL;
            S_MUL:
                state_next = S_CHECK;
            S_CHECK:
            begin
                if (sq_above_hi)
                    state_next = S_COUNT;
                else if (sq_below_lo)
                    state_next = S_DIV;
                else
                    state_next = S_STRIKE;
            end
            S_DIV:
                if (div_last)
                    state_next = S_START;
            S_START:
                state_next = S_STRIKE;
            S_STRIKE:
                if (!strike_more)
                    state_next = S_MUL;
            S_COUNT:
                if (idx_reg[IW-1:0] == last_reg)
                    state_next = S_DRAIN;
            S_DRAIN:
                state_next = S_DONE;
            S_DONE:
                if (!out_valid_reg || out_ready)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // Memory port controls
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = idx_reg[IW-1:0];
        mem_wd = !small_val;
        mem_re = 1'b0;
        mem_ra = idx_reg[IW-1:0];
        unique case (state_reg)
            S_PRESET:
                mem_we = 1'b1;
            S_STRIKE:
            begin
                mem_we = strike_more;
                mem_wa = off_reg[IW-1:0];
                mem_wd = 1'b0;
            end
            S_COUNT:
                mem_re = 1'b1;
            default:
                mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
            mem_q <= mem[mem_ra];
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            rdv_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rdv_reg   <= (state_reg == S_COUNT);
            if (state_reg == S_DONE && (!out_valid_reg || out_ready))
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Sieve datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                lo_reg   <= VALUE_BITS'(job.lo);
                hi_reg   <= VALUE_BITS'(job.hi);
                last_reg <= IW'(job.hi - job.lo);
                wide_reg <= (job.kind == JOB_WIDE);
                idx_reg  <= '0;
                cnt_reg  <= '0;
                x_reg    <= XW'(2);
            end
            S_PRESET:
                idx_reg <= idx_reg + 1'b1;
            S_MUL:
                sq_reg <= x_reg * x_reg;
            S_CHECK:
            begin
                idx_reg  <= '0;
                rem_reg  <= '0;
                dcnt_reg <= '0;
                off_reg  <= OW'(sq_reg - PW'(lo_reg));
            end
            S_DIV:
            begin
                // One quotient bit per cycle; only the remainder is kept
                if (shifted >= {1'b0, x_reg})
                    rem_reg <= XW'(shifted - {1'b0, x_reg});
                else
                    rem_reg <= shifted[XW-1:0];
                dcnt_reg <= dcnt_reg + 1'b1;
            end
            S_START:
                off_reg <= (rem_reg == '0) ? '0 : OW'(x_reg - rem_reg);
            S_STRIKE:
            begin
                if (strike_more)
                    off_reg <= off_reg + OW'(x_reg);
                else
                    x_reg <= (x_reg == XW'(2)) ? XW'(3) : x_reg + XW'(2);
            end
            S_COUNT:
                idx_reg <= idx_reg + 1'b1;
            S_DONE:
                if (!out_valid_reg || out_ready)
                begin
                    out_reg.twin_count      <= cnt_reg;
                    out_reg.window_too_wide <= wide_reg;
                end
            default:
                idx_reg <= idx_reg;
        endcase

        // Count pipeline behind the registered read
        if (rdv_reg)
        begin
            h1_reg  <= mem_q;
            h2_reg  <= h1_reg;
            if (rdi_reg >= (IW+1)'(2) && mem_q && h2_reg)
                cnt_reg <= cnt_reg + 1'b1;
        end
        if (state_reg == S_COUNT)
            rdi_reg <= idx_reg;
    end

    // Checks
    a_wr_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (mem_wa <= last_reg))
        else $error("bitmap write beyond window");

    a_no_wr_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COUNT || state_reg == S_DRAIN) |-> !mem_we)
        else $error("bitmap write during count");

    a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && !out_valid_reg) |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("result not loaded");

endmodule

### src/twin_prime_window_counter_top.sv
// Twin prime window counter, top level: front, job queue, back.
// Each sieve query presets the bitmap over its span, then for each stride x with x*x <= high
//   strikes the multiples of x (after a remainder division when x*x < low), then counts twin pairs;
// empty or too wide queries go straight to the result. The back end takes a new query only when idle.
// Reset clears control state; the bitmap is undefined after reset and needs no clearing.
// Depends on tpwc_pkg, tpwc_front, tpwc_queue, tpwc_back.
module twin_prime_window_counter_top #(
    parameter int WINDOW     = tpwc_pkg::WINDOW_DEF,
    parameter int VALUE_BITS = tpwc_pkg::VALUE_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  tpwc_pkg::in_beat_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output tpwc_pkg::out_beat_t out_data
);
    import tpwc_pkg::*;

    logic f_valid;
    logic f_ready;
    job_t f_job;
    logic b_valid;
    logic b_ready;
    job_t b_job;

    tpwc_front #(.WINDOW(WINDOW), .VALUE_BITS(VALUE_BITS)) u_front (
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .job_valid(f_valid),
        .job_ready(f_ready),
        .job      (f_job)
    );

    tpwc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_valid(f_valid),
        .push_ready(f_ready),
        .push_job  (f_job),
        .pop_valid (b_valid),
        .pop_ready (b_ready),
        .pop_job   (b_job)
    );

    tpwc_back #(.WINDOW(WINDOW), .VALUE_BITS(VALUE_BITS)) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .job_valid(b_valid),
        .job_ready(b_ready),
        .job      (b_job),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

endmodule
